@@ rtl/ttgf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_pkg: shared types and constants for the track trim, gain and fade block
// Register map, item layouts, state machine types and fixed-point constants.
// ----------------------------------------------------------------------------
package ttgf_pkg;

   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_COUNT_WIDTH  = 32;

   localparam int SAMPLE_IN_W  = 24;
   localparam int SAMPLE_OUT_W = 28;
   localparam int CHAN_W       = 3;
   localparam int GAIN_W       = 16;
   localparam int LEN_W        = 32;
   localparam int CCOUNT_W     = 4;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // kept frame index as seen by the envelope unit, saturated at 2^32
   localparam int FRAME_W = LEN_W + 1;
   localparam logic [FRAME_W-1:0] FRAME_SAT = {1'b1, {LEN_W{1'b0}}};

   localparam int ENV_W = 17;
   localparam logic [ENV_W-1:0] ENV_ONE = {1'b1, {(ENV_W-1){1'b0}}};
   localparam int DIV_STEPS = ENV_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam int MAG_W   = SAMPLE_IN_W;
   localparam int TPROD_W = MAG_W + GAIN_W;
   localparam int TSPLIT  = TPROD_W / 2;
   localparam int PPROD_W = TSPLIT + ENV_W;
   localparam int PROD_W  = TPROD_W + ENV_W;
   localparam int RSHIFT  = 28;
   localparam int ROUND_W = PROD_W - RSHIFT;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (RSHIFT - 1);
   localparam logic [ROUND_W-1:0] POS_LIMIT = ROUND_W'(28'h7FF_FFFF);
   localparam logic [ROUND_W-1:0] NEG_LIMIT = ROUND_W'(28'h800_0000);

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN       = 3'd0,
      CSR_TRIM_START = 3'd1,
      CSR_KEEP_LEN   = 3'd2,
      CSR_FADE_IN    = 3'd3,
      CSR_FADE_OUT   = 3'd4,
      CSR_CHAN_COUNT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain;
      logic [LEN_W-1:0]    trim_start_frames;
      logic [LEN_W-1:0]    keep_length_frames;
      logic [LEN_W-1:0]    fade_in_frames;
      logic [LEN_W-1:0]    fade_out_frames;
      logic [CCOUNT_W-1:0] channel_count;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain:               16'd4096,
      trim_start_frames:  32'd0,
      keep_length_frames: 32'd0,
      fade_in_frames:     32'd0,
      fade_out_frames:    32'd0,
      channel_count:      4'd2
   };

   // one kept sample on its way from the front to the back
   typedef struct packed {
      logic [SAMPLE_IN_W-1:0] sample;
      logic [CHAN_W-1:0]      chan;
      logic                   last;
      logic                   env_start;
      logic [FRAME_W-1:0]     frame;
   } q_item_type;

   typedef enum logic [2:0] {
      E_IDLE,
      E_CHECK,
      E_WAIT_IN,
      E_CHECK_OUT,
      E_WAIT_OUT,
      E_MUL,
      E_DONE
   } env_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ENV,
      B_MUL_A,
      B_MUL_LO,
      B_MUL_HI,
      B_SUM,
      B_ROUND,
      B_EMIT
   } back_state_type;

endpackage

@@ rtl/ttgf_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_req_if: input sample channel
// Valid/ready channel carrying one interleaved channel sample per item.
// ----------------------------------------------------------------------------
interface ttgf_req_if;
   import ttgf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_IN_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/ttgf_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_rsp_if: result sample channel
// Valid/ready channel carrying one scaled sample with its channel and end flag.
// ----------------------------------------------------------------------------
interface ttgf_rsp_if;
   import ttgf_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_OUT_W-1:0] sample_out;
   logic [CHAN_W-1:0]              channel_index;
   logic                           last_of_track;

   modport source (output valid, output sample_out, output channel_index,
                   output last_of_track, input ready);
   modport sink   (input valid, input sample_out, input channel_index,
                   input last_of_track, output ready);
endinterface

@@ rtl/ttgf_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_csr_if: register write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface ttgf_csr_if;
   import ttgf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ttgf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_front: frame counting and trim classification
// Counts items into frames, drops trimmed and post-end items and hands kept
// samples with their frame index to the queue.
// ----------------------------------------------------------------------------
module ttgf_front #(
   parameter int MAX_CHANNELS = ttgf_pkg::DEF_MAX_CHANNELS,
   parameter int COUNT_WIDTH  = ttgf_pkg::DEF_COUNT_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  ttgf_pkg::cfg_type   cfg_i,
   ttgf_req_if.sink            req_bus,
   input  logic                full_i,
   output logic                push_o,
   output ttgf_pkg::q_item_type item_o
);
   import ttgf_pkg::*;

   localparam int CMP_W = ((COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W) + 1;

   logic [CHAN_W-1:0]      pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] fc_ff, fc_in;
   logic [COUNT_WIDTH-1:0] kc_ff, kc_in;
   logic                   end_ff, end_in;

   logic [4:0]             chans;
   logic                   frame_end;
   logic [CMP_W-1:0]       fc_x, kc_x, trim_x, keep_x, kc_inc_x;
   logic [COUNT_WIDTH-1:0] kc_inc;
   logic                   keep_nz, start_end, end_now, in_trim, keep_item;
   logic                   accept;

   always_comb begin
      if (cfg_i.channel_count == '0) begin
         chans = 5'd1;
      end else if ({1'b0, cfg_i.channel_count} > 5'(MAX_CHANNELS)) begin
         chans = 5'(MAX_CHANNELS);
      end else begin
         chans = {1'b0, cfg_i.channel_count};
      end
   end

   assign frame_end = {2'b00, pos_ff} >= (chans - 5'd1);

   assign fc_x     = CMP_W'(fc_ff);
   assign kc_x     = CMP_W'(kc_ff);
   assign trim_x   = CMP_W'(cfg_i.trim_start_frames);
   assign keep_x   = CMP_W'(cfg_i.keep_length_frames);
   assign kc_inc   = (kc_ff != '1) ? kc_ff + 1'b1 : kc_ff;
   assign kc_inc_x = CMP_W'(kc_inc);
   assign keep_nz  = cfg_i.keep_length_frames != '0;

   // the track end is noticed at the start of a frame
   assign start_end = (pos_ff == '0) && !end_ff && (fc_x >= trim_x) && keep_nz &&
                      (kc_x >= keep_x);
   assign end_now   = end_ff || start_end;
   assign in_trim   = fc_x < trim_x;
   assign keep_item = !end_now && !in_trim;

   assign req_bus.ready = !full_i;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push_o        = accept && keep_item;

   always_comb begin
      item_o.sample    = req_bus.sample_in;
      item_o.chan      = pos_ff;
      item_o.last      = frame_end && keep_nz && ((kc_x + CMP_W'(1)) == keep_x);
      item_o.env_start = pos_ff == '0;
      item_o.frame     = (kc_x > CMP_W'(FRAME_SAT)) ? FRAME_SAT : kc_x[FRAME_W-1:0];
   end

   always_comb begin
      pos_in = pos_ff;
      fc_in  = fc_ff;
      kc_in  = kc_ff;
      end_in = end_ff;
      if (accept) begin
         pos_in = frame_end ? '0 : pos_ff + 1'b1;
         end_in = end_now;
         if (!end_now && in_trim && frame_end && (fc_ff != '1)) begin
            fc_in = fc_ff + 1'b1;
         end
         if (keep_item && frame_end) begin
            kc_in = kc_inc;
            if (keep_nz && (kc_inc_x >= keep_x)) begin
               end_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         fc_ff  <= '0;
         kc_ff  <= '0;
         end_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         fc_ff  <= fc_in;
         kc_ff  <= kc_in;
         end_ff <= end_in;
      end
   end

   a_no_push_after_end: assert property (@(posedge clock) disable iff (reset)
      end_ff |-> !push_o)
      else $error("kept item pushed after the track end");

endmodule

@@ rtl/ttgf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_queue: short item queue between front and back
// Small register queue so that classification and scaling stall separately.
// ----------------------------------------------------------------------------
module ttgf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_i,
   input  ttgf_pkg::q_item_type item_i,
   input  logic                 pop_i,
   output logic                 full_o,
   output logic                 valid_o,
   output ttgf_pkg::q_item_type item_o
);
   import ttgf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full_o  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign valid_o = count_ff != '0;
   assign item_o  = slot_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && valid_o;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_i && !pop_i) |-> (count_ff < CNT_W'(QUEUE_DEPTH)))
      else $error("item pushed into a full queue");

endmodule

@@ rtl/ttgf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_div: fade ratio divider
// Restoring divider for (x * 65536) / d with x <= d, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ttgf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_i,
   input  logic [ttgf_pkg::LEN_W-1:0]    num_i,
   input  logic [ttgf_pkg::LEN_W-1:0]    den_i,
   output logic                          done_o,
   output logic [ttgf_pkg::ENV_W-1:0]    quot_o
);
   import ttgf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]     rem_ff, den_ff;
   logic [ENV_W-1:0]     bits_ff, quot_ff;
   logic [LEN_W:0]       shifted, diff;
   logic                 ge;

   // next dividend bit comes from the low end of x, then the 16 zero bits
   assign shifted = {rem_ff, bits_ff[ENV_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start_i) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_i) begin
         rem_ff  <= {1'b0, num_i[LEN_W-1:1]};
         bits_ff <= {num_i[0], {(ENV_W-1){1'b0}}};
         den_ff  <= den_i;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
         bits_ff <= {bits_ff[ENV_W-2:0], 1'b0};
         quot_ff <= {quot_ff[ENV_W-2:0], ge};
      end
   end

   assign done_o = done_ff;
   assign quot_o = quot_ff;

endmodule

@@ rtl/ttgf_env.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_env: frame envelope unit
// Computes the Q1.16 fade-in times fade-out envelope of one kept frame,
// sharing one divider between the two fade ratios.
// ----------------------------------------------------------------------------
module ttgf_env (
   input  logic                          clock,
   input  logic                          reset,
   input  ttgf_pkg::cfg_type             cfg_i,
   input  logic                          start_i,
   input  logic [ttgf_pkg::FRAME_W-1:0]  frame_i,
   output logic                          done_o,
   output logic [ttgf_pkg::ENV_W-1:0]    env_o
);
   import ttgf_pkg::*;

   env_state_type      state_ff, state_in;
   logic [FRAME_W-1:0] frame_ff;
   logic [ENV_W-1:0]   ein_ff, eout_ff, env_ff;

   logic [LEN_W-1:0]   keep, fi_c, fo_c, out_base, out_pos, out_num;
   logic               keep_nz, full_fade, need_in, need_out;
   logic [FRAME_W-1:0] pos_wide;
   logic [2*ENV_W-1:0] env_prod;

   logic               div_start, div_done;
   logic [LEN_W-1:0]   div_num, div_den;
   logic [ENV_W-1:0]   div_quot;

   assign keep    = cfg_i.keep_length_frames;
   assign keep_nz = keep != '0;
   assign fi_c    = (keep_nz && (cfg_i.fade_in_frames > keep)) ? keep : cfg_i.fade_in_frames;
   assign fo_c    = (keep_nz && (cfg_i.fade_out_frames > keep)) ? keep : cfg_i.fade_out_frames;

   // both fades over the whole track leave nothing audible
   assign full_fade = keep_nz && (fi_c == keep) && (fo_c == keep);
   assign need_in   = (fi_c != '0) && (frame_ff < {1'b0, fi_c});
   assign out_base  = keep - fo_c;
   assign need_out  = keep_nz && (fo_c != '0) && (frame_ff >= {1'b0, out_base}) &&
                      (frame_ff < {1'b0, keep});
   assign pos_wide  = frame_ff - {1'b0, out_base};
   assign out_pos   = pos_wide[LEN_W-1:0];
   assign out_num   = fo_c - out_pos;
   assign env_prod  = ein_ff * eout_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE:      if (start_i) state_in = E_CHECK;
         E_CHECK: begin
            if (full_fade) begin
               state_in = E_DONE;
            end else if (need_in) begin
               state_in = E_WAIT_IN;
            end else begin
               state_in = E_CHECK_OUT;
            end
         end
         E_WAIT_IN:   if (div_done) state_in = E_CHECK_OUT;
         E_CHECK_OUT: state_in = need_out ? E_WAIT_OUT : E_MUL;
         E_WAIT_OUT:  if (div_done) state_in = E_MUL;
         E_MUL:       state_in = E_DONE;
         E_DONE:      state_in = E_IDLE;
         default:     state_in = E_IDLE;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = frame_ff[LEN_W-1:0];
      div_den   = fi_c;
      done_o    = 1'b0;
      unique case (state_ff)
         E_CHECK:     div_start = !full_fade && need_in;
         E_CHECK_OUT: begin
            div_start = need_out;
            div_num   = out_num;
            div_den   = fo_c;
         end
         E_DONE:      done_o = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         E_IDLE: begin
            if (start_i) frame_ff <= frame_i;
         end
         E_CHECK: begin
            ein_ff <= ENV_ONE;
            if (full_fade) env_ff <= '0;
         end
         E_WAIT_IN: begin
            if (div_done) ein_ff <= div_quot;
         end
         E_CHECK_OUT: eout_ff <= ENV_ONE;
         E_WAIT_OUT: begin
            if (div_done) eout_ff <= div_quot;
         end
         E_MUL: env_ff <= env_prod[ENV_W+ENV_W-2:ENV_W-1];
         default: ;
      endcase
   end

   assign env_o = env_ff;

   ttgf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start_i (div_start),
      .num_i   (div_num),
      .den_i   (div_den),
      .done_o  (div_done),
      .quot_o  (div_quot)
   );

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == E_WAIT_IN || state_ff == E_WAIT_OUT))
      else $error("divider finished while the envelope unit was not waiting");

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_DONE) |-> (env_ff <= ENV_ONE))
      else $error("envelope above unity");

endmodule

@@ rtl/ttgf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgf_back: gain and envelope scaling
// Takes kept samples from the queue, refreshes the envelope at frame start,
// scales by gain and envelope with rounding and saturation and fills the output register.
// ----------------------------------------------------------------------------
module ttgf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ttgf_pkg::cfg_type    cfg_i,
   input  logic                 q_valid_i,
   input  ttgf_pkg::q_item_type q_item_i,
   output logic                 q_pop_o,
   ttgf_rsp_if.source           rsp_bus
);
   import ttgf_pkg::*;

   back_state_type      state_ff, state_in;
   q_item_type          item_ff;
   logic [ENV_W-1:0]    env_ff;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [TPROD_W-1:0]  t_ff;
   logic [PPROD_W-1:0]  lo_ff, hi_ff;
   logic [PROD_W-1:0]   prod_ff, rounded;
   logic [ROUND_W-1:0]  r_ff, r_sat, r_neg;

   logic                rsp_valid_ff;
   logic [SAMPLE_OUT_W-1:0] sample_out_ff, sample_res;
   logic [CHAN_W-1:0]   chan_ff;
   logic                last_ff;

   logic                slot_free, load_out, env_start, env_done;
   logic [ENV_W-1:0]    env_val;
   logic [MAG_W-1:0]    head_sample;

   assign slot_free   = !rsp_valid_ff || rsp_bus.ready;
   assign head_sample = q_item_i.sample;
   assign mag_in      = head_sample[MAG_W-1] ? MAG_W'(-head_sample) : head_sample;
   assign rounded     = prod_ff + ROUND_HALF;

   always_comb begin
      r_sat = r_ff;
      if (item_ff.sample[MAG_W-1]) begin
         if (r_ff > NEG_LIMIT) r_sat = NEG_LIMIT;
      end else begin
         if (r_ff > POS_LIMIT) r_sat = POS_LIMIT;
      end
   end
   assign r_neg      = -r_sat;
   assign sample_res = item_ff.sample[MAG_W-1] ? r_neg[SAMPLE_OUT_W-1:0] :
                                                 r_sat[SAMPLE_OUT_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid_i) state_in = q_item_i.env_start ? B_ENV : B_MUL_A;
         end
         B_ENV:    if (env_done) state_in = B_MUL_A;
         B_MUL_A:  state_in = B_MUL_LO;
         B_MUL_LO: state_in = B_MUL_HI;
         B_MUL_HI: state_in = B_SUM;
         B_SUM:    state_in = B_ROUND;
         B_ROUND:  state_in = B_EMIT;
         B_EMIT:   if (slot_free) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop_o   = 1'b0;
      env_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            q_pop_o   = q_valid_i;
            env_start = q_valid_i && q_item_i.env_start;
         end
         B_EMIT:  load_out = slot_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_ENV && env_done) begin
            env_ff <= env_val;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // product split in two halves so each multiply stays narrow
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (q_valid_i) begin
               item_ff <= q_item_i;
               mag_ff  <= mag_in;
            end
         end
         B_MUL_A:  t_ff    <= TPROD_W'(mag_ff) * TPROD_W'(cfg_i.gain);
         B_MUL_LO: lo_ff   <= PPROD_W'(t_ff[TSPLIT-1:0]) * PPROD_W'(env_ff);
         B_MUL_HI: hi_ff   <= PPROD_W'(t_ff[TPROD_W-1:TSPLIT]) * PPROD_W'(env_ff);
         B_SUM:    prod_ff <= PROD_W'({hi_ff, {TSPLIT{1'b0}}}) + PROD_W'(lo_ff);
         B_ROUND:  r_ff    <= rounded[PROD_W-1:RSHIFT];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         sample_out_ff <= sample_res;
         chan_ff       <= item_ff.chan;
         last_ff       <= item_ff.last;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.sample_out    = sample_out_ff;
   assign rsp_bus.channel_index = chan_ff;
   assign rsp_bus.last_of_track = last_ff;

   ttgf_env u_env (
      .clock   (clock),
      .reset   (reset),
      .cfg_i   (cfg_i),
      .start_i (env_start),
      .frame_i (q_item_i.frame),
      .done_o  (env_done),
      .env_o   (env_val)
   );

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_EMIT))
      else $error("result appeared without passing the emit step");

endmodule

@@ rtl/track_trim_gain_fade.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_trim_gain_fade: audio track trim, gain and linear fade in/out
// Drops trimmed frames and frames past the kept length, scales kept samples
// by gain and a per-frame fade envelope, Q1.23 in, Q5.23 out.
// ----------------------------------------------------------------------------
//  port     | dir | payload                                     | moves
//  ---------+-----+---------------------------------------------+------------------
//  req_bus  | in  | sample_in                                   | one sample item
//  rsp_bus  | out | sample_out, channel_index, last_of_track    | zero or one item
//  csr_bus  | in  | index, data                                 | one register write
//
//  dropped item: taken by the front when the queue has room
//  kept item: scaling sequencer, one multiply per cycle, emit waits for room
//  first channel of a frame: up to two 17-step divides
//    in the shared envelope divider
//  a 2-entry queue and the output register decouple input and result stalls
//  reset: synchronous, clears counters and loads register defaults
// ----------------------------------------------------------------------------
module track_trim_gain_fade #(
   parameter int MAX_CHANNELS = ttgf_pkg::DEF_MAX_CHANNELS,
   parameter int COUNT_WIDTH  = ttgf_pkg::DEF_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   ttgf_req_if.sink    req_bus,
   ttgf_rsp_if.source  rsp_bus,
   ttgf_csr_if.sink    csr_bus
);
   import ttgf_pkg::*;

   cfg_type    cfg_ff;
   logic       push, full, q_valid, q_pop;
   q_item_type push_item, head_item;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_GAIN:       cfg_ff.gain               <= csr_bus.data[GAIN_W-1:0];
            CSR_TRIM_START: cfg_ff.trim_start_frames  <= csr_bus.data[LEN_W-1:0];
            CSR_KEEP_LEN:   cfg_ff.keep_length_frames <= csr_bus.data[LEN_W-1:0];
            CSR_FADE_IN:    cfg_ff.fade_in_frames     <= csr_bus.data[LEN_W-1:0];
            CSR_FADE_OUT:   cfg_ff.fade_out_frames    <= csr_bus.data[LEN_W-1:0];
            CSR_CHAN_COUNT: cfg_ff.channel_count      <= csr_bus.data[CCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   ttgf_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg_i   (cfg_ff),
      .req_bus (req_bus),
      .full_i  (full),
      .push_o  (push),
      .item_o  (push_item)
   );

   ttgf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .item_i  (push_item),
      .pop_i   (q_pop),
      .full_o  (full),
      .valid_o (q_valid),
      .item_o  (head_item)
   );

   ttgf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg_i     (cfg_ff),
      .q_valid_i (q_valid),
      .q_item_i  (head_item),
      .q_pop_o   (q_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
